>>> hw/rtl/c8alu_pkg.sv
`timescale 1ns / 1ps

package c8alu_pkg;

  // Status register bit positions.
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  // Widths of the stream payloads.
  localparam int unsigned CmdWidth      = 6;
  localparam int unsigned InUserWidth   = CmdWidth + 1;
  localparam int unsigned InDataWidth   = 8;
  localparam int unsigned OutFieldWidth = 50;
  localparam int unsigned OutDataWidth  = 56;

  // Command codes.
  typedef enum logic [CmdWidth-1:0] {
    CmdNop = 6'd0,  CmdAdc = 6'd1,  CmdSbc = 6'd2,  CmdAnd = 6'd3,
    CmdOra = 6'd4,  CmdEor = 6'd5,  CmdBit = 6'd6,  CmdCmp = 6'd7,
    CmdCpx = 6'd8,  CmdCpy = 6'd9,  CmdLda = 6'd10, CmdLdx = 6'd11,
    CmdLdy = 6'd12, CmdSta = 6'd13, CmdStx = 6'd14, CmdSty = 6'd15,
    CmdAsl = 6'd16, CmdLsr = 6'd17, CmdRol = 6'd18, CmdRor = 6'd19,
    CmdInc = 6'd20, CmdDec = 6'd21, CmdInx = 6'd22, CmdIny = 6'd23,
    CmdDex = 6'd24, CmdDey = 6'd25, CmdTax = 6'd26, CmdTay = 6'd27,
    CmdTxa = 6'd28, CmdTya = 6'd29, CmdTsx = 6'd30, CmdTxs = 6'd31,
    CmdClc = 6'd32, CmdSec = 6'd33, CmdCli = 6'd34, CmdSei = 6'd35,
    CmdCld = 6'd36, CmdSed = 6'd37, CmdClv = 6'd38, CmdPha = 6'd39,
    CmdPhp = 6'd40, CmdPla = 6'd41, CmdPlp = 6'd42, CmdBcc = 6'd43,
    CmdBcs = 6'd44, CmdBeq = 6'd45, CmdBne = 6'd46, CmdBmi = 6'd47,
    CmdBpl = 6'd48, CmdBvc = 6'd49, CmdBvs = 6'd50
  } cmd_e;

  // Architectural register file of the CPU.
  typedef struct packed {
    logic [7:0] p;
    logic [7:0] sp;
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] a;
  } arch_t;

  // Memory-side outcome of one command.
  typedef struct packed {
    logic       taken;
    logic       wen;
    logic [7:0] wdata;
  } side_t;

  // Update Z and N in a status byte from a result value.
  function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r        = p;
    r[FlagZ] = (v == 8'h00);
    r[FlagN] = v[7];
    return r;
  endfunction

endpackage

>>> hw/rtl/c8alu_core.sv
`timescale 1ns / 1ps

module c8alu_core (
  input  c8alu_pkg::cmd_e  cmd_i,
  input  logic             use_acc_i,
  input  logic [7:0]       opnd_i,
  input  c8alu_pkg::arch_t st_i,
  output c8alu_pkg::arch_t st_o,
  output c8alu_pkg::side_t side_o
);
  import c8alu_pkg::*;

  logic       cin;
  logic [7:0] addend;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] src;
  logic       sh_left;
  logic [7:0] sh_res;
  logic [7:0] inc_res;
  logic [7:0] dec_res;

  // Shared datapath pieces: adder, comparator, shifter, plus the memory increment and decrement.
  always_comb begin
    cin     = st_i.p[FlagC];
    addend  = (cmd_i == CmdSbc) ? ~opnd_i : opnd_i;
    sum     = {1'b0, st_i.a} + {1'b0, addend} + {8'd0, cin};
    cmp_reg = (cmd_i == CmdCpx) ? st_i.x : ((cmd_i == CmdCpy) ? st_i.y : st_i.a);
    diff    = {1'b0, cmp_reg} - {1'b0, opnd_i};
    src     = use_acc_i ? st_i.a : opnd_i;
    sh_left = (cmd_i == CmdAsl) || (cmd_i == CmdRol);
    sh_res  = sh_left ? {src[6:0], (cmd_i == CmdRol) & cin}
                      : {(cmd_i == CmdRor) & cin, src[7:1]};
    inc_res = opnd_i + 8'd1;
    dec_res = opnd_i - 8'd1;
  end

  // Command decode and register update.
  always_comb begin
    st_o   = st_i;
    side_o = '0;
    case (cmd_i)
      CmdAdc, CmdSbc: begin
        st_o.a        = sum[7:0];
        st_o.p[FlagC] = sum[8];
        st_o.p[FlagV] = ~(st_i.a[7] ^ addend[7]) & (st_i.a[7] ^ sum[7]);
        st_o.p        = set_zn(st_o.p, sum[7:0]);
      end
      CmdAnd: begin
        st_o.a = st_i.a & opnd_i;
        st_o.p = set_zn(st_i.p, st_i.a & opnd_i);
      end
      CmdOra: begin
        st_o.a = st_i.a | opnd_i;
        st_o.p = set_zn(st_i.p, st_i.a | opnd_i);
      end
      CmdEor: begin
        st_o.a = st_i.a ^ opnd_i;
        st_o.p = set_zn(st_i.p, st_i.a ^ opnd_i);
      end
      CmdBit: begin
        st_o.p[FlagZ] = ((st_i.a & opnd_i) == 8'h00);
        st_o.p[FlagV] = opnd_i[6];
        st_o.p[FlagN] = opnd_i[7];
      end
      CmdCmp, CmdCpx, CmdCpy: begin
        st_o.p[FlagC] = ~diff[8];
        st_o.p[FlagZ] = (cmp_reg == opnd_i);
        st_o.p[FlagN] = diff[7];
      end
      CmdLda: begin
        st_o.a = opnd_i;
        st_o.p = set_zn(st_i.p, opnd_i);
      end
      CmdLdx: begin
        st_o.x = opnd_i;
        st_o.p = set_zn(st_i.p, opnd_i);
      end
      CmdLdy: begin
        st_o.y = opnd_i;
        st_o.p = set_zn(st_i.p, opnd_i);
      end
      CmdSta: side_o = '{taken: 1'b0, wen: 1'b1, wdata: st_i.a};
      CmdStx: side_o = '{taken: 1'b0, wen: 1'b1, wdata: st_i.x};
      CmdSty: side_o = '{taken: 1'b0, wen: 1'b1, wdata: st_i.y};
      CmdAsl, CmdLsr, CmdRol, CmdRor: begin
        st_o.p[FlagC] = sh_left ? src[7] : src[0];
        st_o.p        = set_zn(st_o.p, sh_res);
        if (use_acc_i) begin
          st_o.a = sh_res;
        end else begin
          side_o = '{taken: 1'b0, wen: 1'b1, wdata: sh_res};
        end
      end
      CmdInc: begin
        st_o.p = set_zn(st_i.p, inc_res);
        side_o = '{taken: 1'b0, wen: 1'b1, wdata: inc_res};
      end
      CmdDec: begin
        st_o.p = set_zn(st_i.p, dec_res);
        side_o = '{taken: 1'b0, wen: 1'b1, wdata: dec_res};
      end
      CmdInx: begin
        st_o.x = st_i.x + 8'd1;
        st_o.p = set_zn(st_i.p, st_i.x + 8'd1);
      end
      CmdIny: begin
        st_o.y = st_i.y + 8'd1;
        st_o.p = set_zn(st_i.p, st_i.y + 8'd1);
      end
      CmdDex: begin
        st_o.x = st_i.x - 8'd1;
        st_o.p = set_zn(st_i.p, st_i.x - 8'd1);
      end
      CmdDey: begin
        st_o.y = st_i.y - 8'd1;
        st_o.p = set_zn(st_i.p, st_i.y - 8'd1);
      end
      CmdTax: begin
        st_o.x = st_i.a;
        st_o.p = set_zn(st_i.p, st_i.a);
      end
      CmdTay: begin
        st_o.y = st_i.a;
        st_o.p = set_zn(st_i.p, st_i.a);
      end
      CmdTxa: begin
        st_o.a = st_i.x;
        st_o.p = set_zn(st_i.p, st_i.x);
      end
      CmdTya: begin
        st_o.a = st_i.y;
        st_o.p = set_zn(st_i.p, st_i.y);
      end
      CmdTsx: begin
        st_o.x = st_i.sp;
        st_o.p = set_zn(st_i.p, st_i.sp);
      end
      CmdTxs: st_o.sp = st_i.x;
      CmdClc: st_o.p[FlagC] = 1'b0;
      CmdSec: st_o.p[FlagC] = 1'b1;
      CmdCli: st_o.p[FlagI] = 1'b0;
      CmdSei: st_o.p[FlagI] = 1'b1;
      CmdCld: st_o.p[FlagD] = 1'b0;
      CmdSed: st_o.p[FlagD] = 1'b1;
      CmdClv: st_o.p[FlagV] = 1'b0;
      CmdPha, CmdPhp: begin
        side_o  = '{taken: 1'b0, wen: 1'b1,
                    wdata: (cmd_i == CmdPha) ? st_i.a : st_i.p};
        st_o.sp = st_i.sp - 8'd1;
      end
      CmdPla: begin
        st_o.a  = opnd_i;
        st_o.p  = set_zn(st_i.p, opnd_i);
        st_o.sp = st_i.sp + 8'd1;
      end
      CmdPlp: begin
        st_o.p  = opnd_i;
        st_o.sp = st_i.sp + 8'd1;
      end
      CmdBcc: side_o.taken = ~st_i.p[FlagC];
      CmdBcs: side_o.taken =  st_i.p[FlagC];
      CmdBeq: side_o.taken =  st_i.p[FlagZ];
      CmdBne: side_o.taken = ~st_i.p[FlagZ];
      CmdBmi: side_o.taken =  st_i.p[FlagN];
      CmdBpl: side_o.taken = ~st_i.p[FlagN];
      CmdBvc: side_o.taken = ~st_i.p[FlagV];
      CmdBvs: side_o.taken =  st_i.p[FlagV];
      default: begin
        // NOP and undefined codes leave everything unchanged.
        st_o   = st_i;
        side_o = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/cpu8_alu_flags_execute.sv
`timescale 1ns / 1ps
// A request is accepted into the input register and moves on to the result register once the
// result slot is free; the result holds there while m_axis_tready_i is low.
// Throughput: one request per cycle while results are taken; the combinational ALU loop over A, X,
// Y, SP and P feeds the next request directly from the updated registers.
// Reset (rst_ni low, asynchronous): A, X, Y, SP and P clear to zero, both stages empty.

module cpu8_alu_flags_execute (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // operand[7:0]
  input  logic [c8alu_pkg::InDataWidth-1:0]   s_axis_tdata_i,
  // command[5:0], use_accumulator[6]
  input  logic [c8alu_pkg::InUserWidth-1:0]   s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // write_data[7:0], write_enable[8], branch_taken[9], acc_out[17:10], x_out[25:18],
  // y_out[33:26], sp_out[41:34], flags_out[49:42], zero fill[55:50]
  output logic [c8alu_pkg::OutDataWidth-1:0]  m_axis_tdata_o
);
  import c8alu_pkg::*;

  logic                        in_valid_q;
  logic [CmdWidth-1:0]         cmd_q;
  logic                        use_acc_q;
  logic [7:0]                  opnd_q;
  arch_t                       arch_q;
  arch_t                       arch_d;
  side_t                       side_d;
  logic                        out_valid_q;
  logic [OutFieldWidth-1:0]    out_data_q;
  logic                        advance;
  logic                        in_ready;

  // Move from input register to result register when the result slot frees up.
  assign advance  = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign in_ready = !in_valid_q || advance;

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataWidth-OutFieldWidth){1'b0}}, out_data_q};

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      cmd_q     <= s_axis_tuser_i[CmdWidth-1:0];
      use_acc_q <= s_axis_tuser_i[CmdWidth];
      opnd_q    <= s_axis_tdata_i;
    end
  end

  // ALU and flag logic.
  c8alu_core u_core (
    .cmd_i     (cmd_e'(cmd_q)),
    .use_acc_i (use_acc_q),
    .opnd_i    (opnd_q),
    .st_i      (arch_q),
    .st_o      (arch_d),
    .side_o    (side_d)
  );

  // Architectural registers commit with the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q <= '0;
    end else if (advance) begin
      arch_q <= arch_d;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {arch_d.p, arch_d.sp, arch_d.y, arch_d.x, arch_d.a,
                     side_d.taken, side_d.wen, side_d.wdata};
    end
  end

  // A byte is only presented when a write is requested.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q[8] |-> out_data_q[7:0] == 8'h00)
    else $error("write data nonzero without write enable");

  // A branch test never writes memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[9] && out_data_q[8]))
    else $error("branch and write in one result");

  // Registers hold while no request moves to the result stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(arch_q))
    else $error("register file changed without a committed request");

  // The result stage reports the registers just committed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_data_q[49:10] == arch_q)
    else $error("result registers differ from committed state");

endmodule
